/* hdl/epc_pkg.sv */
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types, constants and small helpers for the epoch-to-calendar block.
// ----------------------------------------------------------------------------
package epc_pkg;

  // Width of the shared subtract/compare unit (covers any remainder below 2^18)
  localparam int ALU_W = 18;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 26;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  localparam logic [MUL_B_W-1:0] SECS_PER_DAY  = MUL_B_W'(24 * 60 * 60);
  localparam logic [MUL_B_W-1:0] SECS_PER_HOUR = MUL_B_W'(3600);
  localparam logic [MUL_B_W-1:0] SECS_PER_MIN  = MUL_B_W'(60);

  // Reciprocals for exact quotients over the operand range:
  //   secs / 86400 = (secs >> 7) / 675, tod / 3600 = (tod >> 4) / 225,
  //   rem / 60 = (rem >> 2) / 15
  localparam logic [MUL_B_W-1:0] DAY_RECIP  = MUL_B_W'(50903317);  // ceil(2^35 / 675)
  localparam int                 DAY_SHIFT  = 35;
  localparam logic [MUL_B_W-1:0] HOUR_RECIP = MUL_B_W'(9321);      // ceil(2^21 / 225)
  localparam int                 HOUR_SHIFT = 21;
  localparam logic [MUL_B_W-1:0] MIN_RECIP  = MUL_B_W'(1093);      // ceil(2^14 / 15)
  localparam int                 MIN_SHIFT  = 14;

  localparam logic [11:0] BASE_YEAR = 12'd1970;
  // Residues of the base year for the leap rule
  localparam logic [1:0]  BASE_MOD4   = 2'(1970 % 4);
  localparam logic [6:0]  BASE_MOD100 = 7'(1970 % 100);
  localparam logic [8:0]  BASE_MOD400 = 9'(1970 % 400);
  // 1970-01-01 was a Thursday
  localparam logic [2:0]  BASE_WEEKDAY = 3'd4;

  localparam logic [3:0] LAST_MONTH = 4'd12;
  localparam logic [3:0] FEBRUARY   = 4'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY,
    ST_TOD,
    ST_HOUR,
    ST_HREM,
    ST_MIN,
    ST_MREM,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] diff;
    logic             ge;
  } alu_rsp_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } result_t;

  // Days in a month; February stretches to 29 in leap years
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      FEBRUARY: len = leap ? 5'd29 : 5'd28;
      4'd4,
      4'd6,
      4'd9,
      4'd11:    len = 5'd30;
      default:  len = 5'd31;
    endcase
    return len;
  endfunction

  // Add two weekday residues, result mod 7
  function automatic logic [2:0] add_mod7(input logic [2:0] x, input logic [2:0] y);
    logic [3:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // Reduce a small value (below 42) mod 7 by repeated compare and subtract
  function automatic logic [2:0] small_mod7(input logic [5:0] v);
    logic [5:0] r;
    r = v;
    for (int i = 0; i < 5; i++) begin
      if (r >= 6'd7) begin
        r = r - 6'd7;
      end
    end
    return r[2:0];
  endfunction

endpackage

/* hdl/epc_alu.sv */
// ----------------------------------------------------------------------------
// epc_alu
// Shared subtract and compare unit used by the remainder, year and month steps of the sequencer.
// ----------------------------------------------------------------------------
module epc_alu import epc_pkg::*; (
  input  alu_req_t req,
  output alu_rsp_t rsp
);

  logic [ALU_W:0] full;

  // One wide subtract; the borrow gives the compare
  assign full     = {1'b0, req.a} - {1'b0, req.b};
  assign rsp.diff = full[ALU_W-1:0];
  assign rsp.ge   = ~full[ALU_W];

endmodule

/* hdl/epc_ctrl.sv */
// ----------------------------------------------------------------------------
// epc_ctrl
// Sequencer and working registers: reciprocal multiplies split the second
// count into days, hours, minutes and seconds, then the year and month walks
// run through the shared subtract unit.
// ----------------------------------------------------------------------------
module epc_ctrl import epc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] epoch_seconds,
  input  logic        take,
  output logic        idle,
  output logic        done,
  output result_t     result
);

  state_t state, state_next;

  logic [31:0]        secs;
  logic [ALU_W-1:0]   rem;
  logic [15:0]        days;
  logic [11:0]        year;
  logic [3:0]         month;
  logic [4:0]         hour;
  logic [5:0]         minute;
  logic [1:0]         mod4;
  logic [6:0]         mod100;
  logic [8:0]         mod400;
  logic [2:0]         wd;

  alu_req_t           req;
  alu_rsp_t           rsp;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  logic               leap;
  logic [4:0]         mlen;

  epc_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  // Shared multiplier
  assign prod = {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};

  // Leap rule from the running residues
  assign leap = ((mod4 == 2'd0) && (mod100 != 7'd0)) || (mod400 == 9'd0);
  assign mlen = month_len(month, leap);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (start) state_next = ST_DAY;
      ST_DAY:   state_next = ST_TOD;
      ST_TOD:   state_next = ST_HOUR;
      ST_HOUR:  state_next = ST_HREM;
      ST_HREM:  state_next = ST_MIN;
      ST_MIN:   state_next = ST_MREM;
      ST_MREM:  state_next = ST_YEAR;
      ST_YEAR:  if (!rsp.ge) state_next = ST_MONTH;
      ST_MONTH: if (!rsp.ge || (month == LAST_MONTH)) state_next = ST_DONE;
      ST_DONE:  if (take) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Operand selection and status
  always_comb begin
    req.a = rem;
    req.b = prod[ALU_W-1:0];
    mul_a = '0;
    mul_b = '0;
    idle  = 1'b0;
    done  = 1'b0;
    case (state)
      ST_IDLE:  idle = 1'b1;
      ST_DAY: begin
        mul_a = secs[31:7];
        mul_b = DAY_RECIP;
      end
      ST_TOD: begin
        // Time of day fits in 18 bits, so the low bits of the subtract are exact
        mul_a = {{(MUL_A_W-16){1'b0}}, days};
        mul_b = SECS_PER_DAY;
        req.a = secs[ALU_W-1:0];
      end
      ST_HOUR: begin
        mul_a = {{(MUL_A_W-13){1'b0}}, rem[16:4]};
        mul_b = HOUR_RECIP;
      end
      ST_HREM: begin
        mul_a = {{(MUL_A_W-5){1'b0}}, hour};
        mul_b = SECS_PER_HOUR;
      end
      ST_MIN: begin
        mul_a = {{(MUL_A_W-10){1'b0}}, rem[11:2]};
        mul_b = MIN_RECIP;
      end
      ST_MREM: begin
        mul_a = {{(MUL_A_W-6){1'b0}}, minute};
        mul_b = SECS_PER_MIN;
      end
      ST_YEAR: begin
        req.a = {{(ALU_W-16){1'b0}}, days};
        req.b = leap ? ALU_W'(366) : ALU_W'(365);
      end
      ST_MONTH: begin
        req.a = {{(ALU_W-16){1'b0}}, days};
        req.b = {{(ALU_W-5){1'b0}}, mlen};
      end
      ST_DONE:  done = 1'b1;
      default:  idle = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        secs   <= epoch_seconds;
        year   <= BASE_YEAR;
        month  <= 4'd1;
        mod4   <= BASE_MOD4;
        mod100 <= BASE_MOD100;
        mod400 <= BASE_MOD400;
        wd     <= BASE_WEEKDAY;
      end
      ST_DAY:  days   <= prod[DAY_SHIFT +: 16];
      ST_TOD:  rem    <= rsp.diff;
      ST_HOUR: hour   <= prod[HOUR_SHIFT +: 5];
      ST_HREM: rem    <= rsp.diff;
      ST_MIN:  minute <= prod[MIN_SHIFT +: 6];
      ST_MREM: rem    <= rsp.diff;
      ST_YEAR: begin
        if (rsp.ge) begin
          days   <= rsp.diff[15:0];
          year   <= year + 12'd1;
          mod4   <= mod4 + 2'd1;
          mod100 <= (mod100 == 7'd99) ? 7'd0 : mod100 + 7'd1;
          mod400 <= (mod400 == 9'd399) ? 9'd0 : mod400 + 9'd1;
          // 365 mod 7 is 1, 366 mod 7 is 2
          wd     <= add_mod7(wd, leap ? 3'd2 : 3'd1);
        end
      end
      ST_MONTH: begin
        if (rsp.ge && (month != LAST_MONTH)) begin
          days  <= rsp.diff[15:0];
          month <= month + 4'd1;
          // Month lengths 28..31 leave residues 0..3
          wd    <= add_mod7(wd, mlen[2:0] - 3'd4);
        end
      end
      default: begin
      end
    endcase
  end

  // Result fields; second is what is left after the minute step
  assign result.year         = year;
  assign result.month        = month;
  assign result.day_of_month = days[4:0] + 5'd1;
  assign result.hour         = hour;
  assign result.minute       = minute;
  assign result.second       = rem[5:0];
  assign result.weekday      = small_mod7({3'd0, wd} + {1'b0, days[4:0]});

endmodule

/* hdl/epoch_seconds_to_calendar.sv */
// Requests: one at a time; in_ready is high only while the sequencer is idle, and the
//   year walk dominates the time that each request takes.
// Stalls: a result still held in the output register keeps the sequencer waiting.
// Reset: rst (synchronous) returns the sequencer to idle and drops out_valid.
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar
// Converts unsigned seconds since 1970-01-01 00:00:00 into Gregorian date,
// time of day and weekday.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar import epc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] year,
  output logic [3:0]  month,
  output logic [4:0]  day_of_month,
  output logic [4:0]  hour,
  output logic [5:0]  minute,
  output logic [5:0]  second,
  output logic [2:0]  weekday
);

  logic    idle;
  logic    done;
  logic    take;
  result_t result;
  result_t hold;

  // Output register is free when empty or being drained
  assign take = ~out_valid | out_ready;

  epc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .start         (in_valid & idle),
    .epoch_seconds (epoch_seconds),
    .take          (take),
    .idle          (idle),
    .done          (done),
    .result        (result)
  );

  assign in_ready = idle;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (done && take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done && take) begin
      hold <= result;
    end
  end

  assign year         = hold.year;
  assign month        = hold.month;
  assign day_of_month = hold.day_of_month;
  assign hour         = hold.hour;
  assign minute       = hold.minute;
  assign second       = hold.second;
  assign weekday      = hold.weekday;

endmodule

/* bench/tb_epoch_seconds_to_calendar.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar
// Sends epoch second counts to the converter and checks each calendar result
// against a date predictor in the bench: fixed corner values, year turnovers,
// values near day and hour edges, and uniform random counts, with random
// stalls on both handshakes.
// ----------------------------------------------------------------------------
module tb_epoch_seconds_to_calendar;
  import epc_pkg::*;

  localparam int unsigned DAY_SECS = 86400;
  localparam int unsigned MAX_DAY = 49710;
  localparam int unsigned MON_LEN [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] epoch_seconds;
  logic        out_valid;
  logic        out_ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day_of_month;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  logic [2:0]  weekday;

  result_t expected_dates[$];
  int      errors;
  bit      idle_bursts;
  int      ready_hold;

  epoch_seconds_to_calendar u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .epoch_seconds(epoch_seconds),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .hour         (hour),
    .minute       (minute),
    .second       (second),
    .weekday      (weekday)
  );

  always #1 clk = ~clk;

  // Gregorian leap rule
  function automatic bit leap_year(input int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned year_span(input int unsigned y);
    return leap_year(y) ? 366 : 365;
  endfunction

  function automatic int unsigned month_span(input int unsigned m, input int unsigned y);
    if (m == 2 && leap_year(y)) begin
      return 29;
    end
    return MON_LEN[m - 1];
  endfunction

  // Expected date and time for one second count
  function automatic result_t calendar_of(input logic [31:0] secs);
    result_t     r;
    int unsigned days;
    int unsigned tod;
    int unsigned yr;
    int unsigned mon;
    int unsigned mlen;
    int unsigned zy;
    int unsigned zm;
    int unsigned zsum;
    days = secs / DAY_SECS;
    tod  = secs % DAY_SECS;
    yr   = 1970;
    while (days >= year_span(yr)) begin
      days -= year_span(yr);
      yr++;
    end
    mon  = 1;
    mlen = month_span(mon, yr);
    while (days >= mlen && mon < 12) begin
      days -= mlen;
      mon++;
      mlen = month_span(mon, yr);
    end
    // Jan and Feb count as months 13 and 14 of the year before
    zy = yr;
    zm = mon;
    if (zm < 3) begin
      zm += 12;
      zy -= 1;
    end
    zsum = (days + 1) + 2 * zm + (3 * (zm + 1)) / 5 + zy + zy / 4 - zy / 100 + zy / 400 + 1;
    r.year         = 12'(yr);
    r.month        = 4'(mon);
    r.day_of_month = 5'(days + 1);
    r.hour         = 5'(tod / 3600);
    r.minute       = 6'((tod % 3600) / 60);
    r.second       = 6'(tod % 60);
    r.weekday      = 3'(zsum % 7);
    return r;
  endfunction

  task automatic report_field(input string name, input int unsigned exp_val,
                              input int unsigned act_val);
    if (exp_val != act_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_val, act_val);
    end
  endtask

  // One request: optional gap, then hold valid until accepted
  task automatic send_request(input logic [31:0] secs);
    if (idle_bursts && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    in_valid      <= 1'b1;
    epoch_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_dates.push_back(calendar_of(secs));
    @(negedge clk);
  endtask

  // Hold off the sender until every pending result is out
  task automatic drain_results();
    in_valid <= 1'b0;
    wait (expected_dates.size() == 0);
    @(negedge clk);
  endtask

  task automatic test_corner_values();
    logic [31:0] corners [25];
    corners = '{32'd0, 32'd1, 32'd59, 32'd60, 32'd3599, 32'd3600, 32'd86399, 32'd86400,
                32'd31535999, 32'd31536000, 32'd68169600, 32'd94608000,
                32'd946684799, 32'd946684800, 32'd951782399, 32'd951782400,
                32'd951868800, 32'd2147483647, 32'd2147483648,
                32'd4107542399, 32'd4107542400, 32'd4294967294, 32'd4294967295,
                32'hAAAA_AAAA, 32'h5555_5555};
    foreach (corners[i]) begin
      send_request(corners[i]);
    end
    drain_results();
  endtask

  // Last second of each year and first second of the next
  task automatic test_year_turnovers();
    longint unsigned start_day;
    longint unsigned secs;
    start_day = 0;
    for (int unsigned yr = 1970; yr < 2106; yr++) begin
      start_day += year_span(yr);
      secs = start_day * DAY_SECS;
      send_request(32'(secs - 1));
      send_request(32'(secs));
    end
  endtask

  // Random day with time of day at a day or hour edge, or anywhere in the day
  task automatic test_near_edges(input int count);
    longint unsigned secs;
    int unsigned     tod;
    int unsigned     day;
    for (int i = 0; i < count; i++) begin
      day = $urandom_range(0, MAX_DAY);
      case ($urandom_range(0, 3))
        0: tod = 0;
        1: tod = DAY_SECS - 1;
        2: tod = 3600 * $urandom_range(0, 23) + ($urandom_range(0, 1) ? 3599 : 0);
        default: tod = $urandom_range(0, DAY_SECS - 1);
      endcase
      secs = longint'(day) * DAY_SECS + tod;
      if (secs > 64'hFFFF_FFFF) begin
        secs = 64'hFFFF_FFFF - $urandom_range(0, 1000);
      end
      send_request(32'(secs));
    end
  endtask

  task automatic test_uniform_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_request($urandom);
      if (i % 150 == 149) begin
        drain_results();
      end
    end
  endtask

  // Result stalls: random bursts while enabled
  always @(negedge clk) begin
    if (ready_hold > 0) begin
      ready_hold--;
      out_ready <= 1'b0;
    end else if (idle_bursts && $urandom_range(0, 5) == 0) begin
      ready_hold = $urandom_range(1, 18) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest expected date
  always @(posedge clk) begin
    result_t exp_date;
    if (!rst && out_valid && out_ready) begin
      if (expected_dates.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d %0d:%0d:%0d wd %0d",
                 $realtime, year, month, day_of_month, hour, minute, second, weekday);
      end else begin
        exp_date = expected_dates.pop_front();
        report_field("year", exp_date.year, year);
        report_field("month", exp_date.month, month);
        report_field("day_of_month", exp_date.day_of_month, day_of_month);
        report_field("hour", exp_date.hour, hour);
        report_field("minute", exp_date.minute, minute);
        report_field("second", exp_date.second, second);
        report_field("weekday", exp_date.weekday, weekday);
      end
    end
  end

  initial begin
    #2_500_000;
    $display("tb_epoch_seconds_to_calendar: errors");
    $finish;
  end

  initial begin
    clk           = 1'b0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    epoch_seconds = '0;
    out_ready     = 1'b0;
    errors        = 0;
    idle_bursts   = 1'b1;
    ready_hold    = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_corner_values();
    test_year_turnovers();
    test_near_edges(400);
    test_uniform_random(600);
    // closing stretch runs without stalls
    idle_bursts = 1'b0;
    test_uniform_random(120);

    in_valid <= 1'b0;
    wait (expected_dates.size() == 0);
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_epoch_seconds_to_calendar: clean");
    end else begin
      $display("tb_epoch_seconds_to_calendar: errors");
    end
    $finish;
  end

endmodule
